// File: hdl/gcb_pkg.sv
`default_nettype none

package gcb_pkg;

    // largest glyph side in pixels
    localparam int unsigned MAX_DIM = 256;
    localparam int unsigned DIM_W   = $clog2(MAX_DIM + 1);
    localparam int unsigned POS_W   = $clog2(MAX_DIM);
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned DIVC_W  = $clog2(DIM_W + 1);

    // register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // balance codes
    localparam logic [1:0] CODE_LIGHTER  = 2'd1;
    localparam logic [1:0] CODE_BALANCED = 2'd2;
    localparam logic [1:0] CODE_HEAVIER  = 2'd3;

    typedef enum logic [3:0] {
        S_PREP = 4'b0001,
        S_DIV  = 4'b0010,
        S_RUN  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [1:0] balance_code(input logic [CNT_W-1:0] top,
                                                input logic [CNT_W-1:0] bottom);
        logic [1:0] c;
        if (top < bottom)
            c = CODE_LIGHTER;
        else if (top > bottom)
            c = CODE_HEAVIER;
        else
            c = CODE_BALANCED;
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hdl/glyph_compass_balance.sv
`default_nettype none

// channel   direction  handshake             payload
// in        sink       in_valid / in_stall   letter
// out       source     out_valid / out_stall upright_code, turned_code, direction
// cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// a pixel item is taken in one cycle while a row is running
// each row first passes through the setup state S_PREP; a scored row then runs
// the shared restoring divider (S_DIV) that works out width/k for the window inset
// before its pixels are taken; in stays stalled outside a running row
// after the last pixel of the turned pass the result waits in the output
// register and no pixel is taken until it is accepted
// rst_n clears all control state; any config write restarts the stream

module glyph_compass_balance (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       letter,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [1:0]                      upright_code,
    output logic [1:0]                      turned_code,
    output logic [3:0]                      direction,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic                       cfg_index,
    input  wire logic [gcb_pkg::DIM_W-1:0]  cfg_data
);

    localparam int unsigned DW = gcb_pkg::DIM_W;
    localparam int unsigned PW = gcb_pkg::POS_W;
    localparam int unsigned CW = gcb_pkg::CNT_W;
    localparam int unsigned VW = gcb_pkg::DIVC_W;

    // configuration
    logic [DW-1:0] width_reg, width_next;
    logic [DW-1:0] height_reg, height_next;

    // sequencer and stream position
    gcb_pkg::state_t state_reg, state_next;
    logic            pass_reg, pass_next;
    logic [PW-1:0]   row_reg, row_next;
    logic [PW-1:0]   col_reg, col_next;
    logic [CW-1:0]   top_cnt_reg, top_cnt_next;
    logic [CW-1:0]   bot_cnt_reg, bot_cnt_next;
    logic [1:0]      first_code_reg, first_code_next;

    // row setup
    logic            scored_reg, scored_next;
    logic            is_top_reg, is_top_next;
    logic [PW-1:0]   k_reg, k_next;
    logic [PW-1:0]   inset_reg, inset_next;

    // shared divider
    logic [PW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]   quo_reg, quo_next;
    logic [VW-1:0]   div_cnt_reg, div_cnt_next;

    // result registers
    logic [1:0]      up_code_reg, up_code_next;
    logic [1:0]      tn_code_reg, tn_code_next;

    logic            cfg_fire;
    logic            in_fire;
    logic [DW-1:0]   w_up, h_up, cur_w, cur_h, hh;
    logic [DW-1:0]   row9, col9, inset9, row_inc, col_inc;
    logic            row_top, row_bot;
    logic [DW-1:0]   k9;
    logic [DW-1:0]   rem_sh, rem_diff;
    logic            q_bit;
    logic [DW-1:0]   quo_final, inset_calc;
    logic            in_window, counted;
    logic [CW-1:0]   top_upd, bot_upd;
    logic [1:0]      pass_code;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_stall  = (state_reg != gcb_pkg::S_RUN);
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = (state_reg == gcb_pkg::S_OUT);

    assign upright_code = up_code_reg;
    assign turned_code  = tn_code_reg;
    assign direction    = {tn_code_reg, up_code_reg};

    // current pass geometry, turned pass swaps the sides
    assign w_up  = gcb_pkg::clamp_dim(width_reg);
    assign h_up  = gcb_pkg::clamp_dim(height_reg);
    assign cur_w = pass_reg ? h_up : w_up;
    assign cur_h = pass_reg ? w_up : h_up;
    assign hh    = cur_h >> 1;

    assign row9    = {1'b0, row_reg};
    assign col9    = {1'b0, col_reg};
    assign inset9  = {1'b0, inset_reg};
    assign row_inc = row9 + DW'(1);
    assign col_inc = col9 + DW'(1);

    // k is the distance from the nearer outer edge plus one, zero for the middle row
    assign row_top = (row9 < hh);
    assign row_bot = (row9 >= (cur_h - hh));
    assign k9      = row_top ? row_inc : (row_bot ? (cur_h - row9) : '0);

    // one restoring step a cycle
    assign rem_sh    = {rem_reg, quo_reg[DW-1]};
    assign q_bit     = (rem_sh >= {1'b0, k_reg});
    assign rem_diff  = q_bit ? (rem_sh - {1'b0, k_reg}) : rem_sh;
    assign quo_final = {quo_reg[DW-2:0], q_bit};
    assign inset_calc = (cur_w >> 1) - (quo_final >> 1);

    // funnel window test and count update
    assign in_window = (col9 >= inset9) && (col9 < (cur_w - inset9));
    assign counted   = scored_reg && letter && in_window;
    assign top_upd   = top_cnt_reg + CW'(counted && is_top_reg);
    assign bot_upd   = bot_cnt_reg + CW'(counted && !is_top_reg);
    assign pass_code = gcb_pkg::balance_code(top_upd, bot_upd);

    always_comb
    begin
        width_next      = width_reg;
        height_next     = height_reg;
        state_next      = state_reg;
        pass_next       = pass_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        top_cnt_next    = top_cnt_reg;
        bot_cnt_next    = bot_cnt_reg;
        first_code_next = first_code_reg;
        scored_next     = scored_reg;
        is_top_next     = is_top_reg;
        k_next          = k_reg;
        inset_next      = inset_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        div_cnt_next    = div_cnt_reg;
        up_code_next    = up_code_reg;
        tn_code_next    = tn_code_reg;

        unique case (state_reg)
            gcb_pkg::S_PREP:
            begin
                // classify the row and start the inset division if it is scored
                scored_next = row_top || row_bot;
                is_top_next = row_top;
                k_next      = k9[PW-1:0];
                rem_next    = '0;
                quo_next    = cur_w;
                div_cnt_next = VW'(DW);
                if (row_top || row_bot)
                    state_next = gcb_pkg::S_DIV;
                else
                    state_next = gcb_pkg::S_RUN;
            end
            gcb_pkg::S_DIV:
            begin
                rem_next     = rem_diff[PW-1:0];
                quo_next     = quo_final;
                div_cnt_next = div_cnt_reg - VW'(1);
                if (div_cnt_reg == VW'(1))
                begin
                    inset_next = inset_calc[PW-1:0];
                    state_next = gcb_pkg::S_RUN;
                end
            end
            gcb_pkg::S_RUN:
            begin
                if (in_fire)
                begin
                    top_cnt_next = top_upd;
                    bot_cnt_next = bot_upd;
                    col_next     = col_inc[PW-1:0];
                    if (col_inc >= cur_w)
                    begin
                        col_next   = '0;
                        row_next   = row_inc[PW-1:0];
                        state_next = gcb_pkg::S_PREP;
                        if (row_inc >= cur_h)
                        begin
                            // end of pass
                            row_next     = '0;
                            inset_next   = '0;
                            top_cnt_next = '0;
                            bot_cnt_next = '0;
                            if (!pass_reg)
                            begin
                                first_code_next = pass_code;
                                pass_next       = 1'b1;
                            end
                            else
                            begin
                                up_code_next    = first_code_reg;
                                tn_code_next    = pass_code;
                                pass_next       = 1'b0;
                                first_code_next = '0;
                                state_next      = gcb_pkg::S_OUT;
                            end
                        end
                    end
                end
            end
            gcb_pkg::S_OUT:
            begin
                if (!out_stall)
                    state_next = gcb_pkg::S_PREP;
            end
            default:
            begin
                state_next = gcb_pkg::S_PREP;
            end
        endcase

        // a register write restarts the stream
        if (cfg_fire)
        begin
            unique case (cfg_index)
                gcb_pkg::REG_WIDTH:  width_next  = cfg_data;
                gcb_pkg::REG_HEIGHT: height_next = cfg_data;
                default:             width_next  = cfg_data;
            endcase
            state_next      = gcb_pkg::S_PREP;
            pass_next       = 1'b0;
            row_next        = '0;
            col_next        = '0;
            inset_next      = '0;
            top_cnt_next    = '0;
            bot_cnt_next    = '0;
            first_code_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= DW'(1);
            height_reg     <= DW'(1);
            state_reg      <= gcb_pkg::S_PREP;
            pass_reg       <= 1'b0;
            row_reg        <= '0;
            col_reg        <= '0;
            top_cnt_reg    <= '0;
            bot_cnt_reg    <= '0;
            first_code_reg <= '0;
            inset_reg      <= '0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            width_reg      <= width_next;
            height_reg     <= height_next;
            state_reg      <= state_next;
            pass_reg       <= pass_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            top_cnt_reg    <= top_cnt_next;
            bot_cnt_reg    <= bot_cnt_next;
            first_code_reg <= first_code_next;
            inset_reg      <= inset_next;
            div_cnt_reg    <= div_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        scored_reg  <= scored_next;
        is_top_reg  <= is_top_next;
        k_reg       <= k_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        up_code_reg <= up_code_next;
        tn_code_reg <= tn_code_next;
    end

    // a pixel is only taken while a row runs and no result is pending
    a_in_only_running: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> (state_reg == gcb_pkg::S_RUN) && !out_valid)
        else $error("pixel taken outside a running row");

    // the window inset never passes the middle of the row
    a_inset_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gcb_pkg::S_RUN) |-> (inset9 <= (cur_w >> 1)))
        else $error("window inset beyond half width");

    // a taken result leaves the block at the start of an upright pass
    a_restart_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> (!pass_reg && row_reg == '0 && col_reg == '0
            && state_reg == gcb_pkg::S_PREP))
        else $error("stream not restarted after result");

    // the divider runs only for a scored row with a nonzero divisor
    a_div_scored: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gcb_pkg::S_DIV) |-> (scored_reg && k_reg != '0))
        else $error("division started for an unscored row");

endmodule

`default_nettype wire
